// ----- design/cmbs_pkg.sv -----
// Package for the cube map bilinear sampler: word types, function codes
// and face codes. No dependencies; the core and its checker use it.
`default_nettype none

package cmbs_pkg;

   localparam int FACE_SIZE_DEFAULT = 32;
   localparam int FACE_COUNT        = 6;
   localparam int IDX_W             = 13;
   localparam int RAD_W             = 21;
   localparam int DIR_W             = 16;

   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   localparam logic [2:0] FACE_POS_X = 3'd0;
   localparam logic [2:0] FACE_NEG_X = 3'd1;
   localparam logic [2:0] FACE_POS_Y = 3'd2;
   localparam logic [2:0] FACE_NEG_Y = 3'd3;
   localparam logic [2:0] FACE_POS_Z = 3'd4;
   localparam logic [2:0] FACE_NEG_Z = 3'd5;

   typedef struct packed {
      logic [RAD_W-1:0] red;
      logic [RAD_W-1:0] green;
      logic [RAD_W-1:0] blue;
   } texel_type;

   typedef struct packed {
      logic                    func;
      logic [IDX_W-1:0]        texel_index;
      logic [RAD_W-1:0]        write_red;
      logic [RAD_W-1:0]        write_green;
      logic [RAD_W-1:0]        write_blue;
      logic signed [DIR_W-1:0] dir_x;
      logic signed [DIR_W-1:0] dir_y;
      logic signed [DIR_W-1:0] dir_z;
   } req_type;

   typedef struct packed {
      logic [RAD_W-1:0] red;
      logic [RAD_W-1:0] green;
      logic [RAD_W-1:0] blue;
   } rsp_type;

endpackage

`default_nettype wire

// ----- design/cube_map_bilinear_sampler_core.sv -----
// Cube map bilinear sampler core: banked texel store, pipelined face
// divider and bilinear blend. Depends on cmbs_pkg.
`default_nettype none

//  channel  | direction | word                 | handshake
//  ---------+-----------+----------------------+-------------------------
//  req_     | in        | cmbs_pkg::req_type   | req_valid / req_ready
//  rsp_     | out       | cmbs_pkg::rsp_type   | rsp_valid / rsp_ready
//
// One word is taken every cycle unless an rsp_ready stall backs up to req_ready. A
// sample word passes P0, P1, P2, the divider, the store read, the blend and
// the output register; the divider resolves one quotient bit per stage.
// A write word gives no result. Reset clears only the stage valid bits; the
// texel store is undefined until written. Each stage loads when it is empty
// or the stage after it moves, so bubbles close up under rsp_ready stalls.
module cube_map_bilinear_sampler_core #(
   parameter int FACE_SIZE = cmbs_pkg::FACE_SIZE_DEFAULT
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  cmbs_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output cmbs_pkg::rsp_type   rsp_data
);

   localparam int IDX_W       = cmbs_pkg::IDX_W;
   localparam int RAD_W       = cmbs_pkg::RAD_W;
   localparam int DIR_W       = cmbs_pkg::DIR_W;
   localparam int NUM_W       = DIR_W + 1;
   localparam int CW          = (FACE_SIZE > 1) ? $clog2(FACE_SIZE) : 1;
   localparam int HALF        = (FACE_SIZE + 1) / 2;
   localparam int BANK_DEPTH  = cmbs_pkg::FACE_COUNT * HALF * HALF;
   localparam int BAW         = $clog2(BANK_DEPTH);
   localparam int STORE_DEPTH = cmbs_pkg::FACE_COUNT * FACE_SIZE * FACE_SIZE;
   localparam int QW          = $clog2(256 * FACE_SIZE + 1);
   localparam int RW          = DIR_W + QW;
   localparam int PW          = QW + 1;
   localparam int IW          = PW - 8;
   localparam int RCP_SHIFT   = IDX_W + $clog2(FACE_SIZE);
   localparam int RCP_MULT    = ((1 << RCP_SHIFT) + FACE_SIZE - 1) / FACE_SIZE;
   localparam int RCP_PW      = IDX_W + RCP_SHIFT + 1;
   localparam int DIV_SCALE   = 128 * FACE_SIZE;
   localparam int TW          = RAD_W + 8;
   localparam int SW          = RAD_W + 16;
   localparam int ROUND_HALF  = 1 << 15;

   // Stage numbering along the single in-order pipeline.
   localparam int ST_P0    = 0;
   localparam int ST_P1    = 1;
   localparam int ST_P2    = 2;
   localparam int ST_DIV   = 3;
   localparam int ST_MEM   = ST_DIV + QW;
   localparam int ST_BLEND = ST_MEM + 1;
   localparam int ST_OUT   = ST_BLEND + 1;
   localparam int NS       = ST_OUT + 1;

   typedef struct packed {
      logic                sample;
      logic                wr_ok;
      logic [2:0]          face;
      logic [CW-1:0]       row;
      logic [CW-1:0]       col;
      cmbs_pkg::texel_type tex;
   } meta_type;

   typedef struct packed {
      logic [DIR_W-1:0] a;
      logic [RW-1:0]    ru;
      logic [RW-1:0]    rv;
      logic [QW-1:0]    qu;
      logic [QW-1:0]    qv;
      meta_type         meta;
   } div_type;

   // Exact floor(n / FACE_SIZE) for any 13-bit n, by reciprocal multiply.
   function automatic logic [IDX_W-1:0] div_by_size(input logic [IDX_W-1:0] n);
      logic [RCP_PW-1:0] p;
      p = RCP_PW'(n) * RCP_PW'(RCP_MULT);
      return IDX_W'(p >> RCP_SHIFT);
   endfunction

   function automatic logic [TW-1:0] lerp_row(input logic [RAD_W-1:0] t0,
                                              input logic [RAD_W-1:0] t1,
                                              input logic [7:0] f);
      logic [8:0] w0;
      w0 = 9'd256 - {1'b0, f};
      return TW'(t0) * TW'(w0) + TW'(t1) * TW'(f);
   endfunction

   function automatic logic [RAD_W-1:0] lerp_col(input logic [TW-1:0] t0,
                                                 input logic [TW-1:0] t1,
                                                 input logic [7:0] f);
      logic [8:0]    w0;
      logic [SW-1:0] s;
      w0 = 9'd256 - {1'b0, f};
      s  = SW'(t0) * SW'(w0) + SW'(t1) * SW'(f) + SW'(ROUND_HALF);
      return RAD_W'(s >> 16);
   endfunction

   // ------------------------------------------------------------------
   // Stage valid bits and load enables. A stage loads when it is empty
   // or its successor loads; the output register is the last stage.
   // ------------------------------------------------------------------
   logic [NS-1:0] v_ff;
   logic [NS-1:0] v_in;
   logic [NS-1:0] ld;
   logic          m_sample_ff;

   always_comb begin
      ld[NS-1] = !v_ff[NS-1] || rsp_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         ld[k] = !v_ff[k] || ld[k+1];
      end
      v_in[0] = req_valid;
      for (int k = 1; k < NS; k++) begin
         v_in[k] = v_ff[k-1];
      end
      // Write words leave the pipeline once they have reached the store.
      v_in[ST_BLEND] = v_ff[ST_MEM] && m_sample_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (ld[k]) begin
               v_ff[k] <= v_in[k];
            end
         end
      end
   end

   assign req_ready = ld[ST_P0];
   assign rsp_valid = v_ff[ST_OUT];

   // ------------------------------------------------------------------
   // P0: input register; the first step of splitting a write address.
   // ------------------------------------------------------------------
   cmbs_pkg::req_type p0_req_ff;
   logic [IDX_W-1:0]  p0_q1_ff;

   always_ff @(posedge clock) begin
      if (ld[ST_P0]) begin
         p0_req_ff <= req_data;
         p0_q1_ff  <= div_by_size(req_data.texel_index);
      end
   end

   // ------------------------------------------------------------------
   // P1: face selection and coordinate numerators; write column.
   // ------------------------------------------------------------------
   logic signed [DIR_W:0]   xs, ys, zs, ax, ay, az, a_sel, su, sv;
   logic signed [DIR_W+1:0] nu_w, nv_w;
   logic [2:0]              face_sel;
   logic                    dir_zero;

   always_comb begin
      xs = (DIR_W+1)'(p0_req_ff.dir_x);
      ys = (DIR_W+1)'(p0_req_ff.dir_y);
      zs = (DIR_W+1)'(p0_req_ff.dir_z);
      ax = xs[DIR_W] ? -xs : xs;
      ay = ys[DIR_W] ? -ys : ys;
      az = zs[DIR_W] ? -zs : zs;
      if (ax >= ay && ax >= az) begin
         a_sel = ax;
         sv    = -ys;
         if (!xs[DIR_W]) begin
            face_sel = cmbs_pkg::FACE_POS_X;
            su       = -zs;
         end else begin
            face_sel = cmbs_pkg::FACE_NEG_X;
            su       = zs;
         end
      end else if (ay >= az) begin
         a_sel = ay;
         su    = xs;
         if (!ys[DIR_W]) begin
            face_sel = cmbs_pkg::FACE_POS_Y;
            sv       = zs;
         end else begin
            face_sel = cmbs_pkg::FACE_NEG_Y;
            sv       = -zs;
         end
      end else begin
         a_sel = az;
         sv    = -ys;
         if (!zs[DIR_W]) begin
            face_sel = cmbs_pkg::FACE_POS_Z;
            su       = xs;
         end else begin
            face_sel = cmbs_pkg::FACE_NEG_Z;
            su       = -xs;
         end
      end
      nu_w     = (DIR_W+2)'(a_sel) + (DIR_W+2)'(su);
      nv_w     = (DIR_W+2)'(a_sel) + (DIR_W+2)'(sv);
      dir_zero = (a_sel == '0);
   end

   logic                p1_sample_ff;
   logic                p1_wr_ok_ff;
   logic [2:0]          p1_face_ff;
   logic [DIR_W-1:0]    p1_a_ff;
   logic [NUM_W-1:0]    p1_nu_ff, p1_nv_ff;
   logic [IDX_W-1:0]    p1_q1_ff, p1_q2_ff;
   logic [CW-1:0]       p1_col_ff;
   cmbs_pkg::texel_type p1_tex_ff;

   always_ff @(posedge clock) begin
      if (ld[ST_P1]) begin
         p1_sample_ff <= (p0_req_ff.func == cmbs_pkg::FUNC_SAMPLE);
         p1_wr_ok_ff  <= RCP_PW'(p0_req_ff.texel_index) < RCP_PW'(STORE_DEPTH);
         p1_face_ff   <= face_sel;
         // A zero direction behaves as a = 1 with both numerators at 1,
         // which lands on the center of face 0.
         p1_a_ff      <= dir_zero ? DIR_W'(1) : a_sel[DIR_W-1:0];
         p1_nu_ff     <= dir_zero ? NUM_W'(1) : nu_w[NUM_W-1:0];
         p1_nv_ff     <= dir_zero ? NUM_W'(1) : nv_w[NUM_W-1:0];
         p1_q1_ff     <= p0_q1_ff;
         p1_q2_ff     <= div_by_size(p0_q1_ff);
         p1_col_ff    <= CW'(p0_req_ff.texel_index - IDX_W'(p0_q1_ff * IDX_W'(FACE_SIZE)));
         p1_tex_ff    <= '{red:   p0_req_ff.write_red,
                           green: p0_req_ff.write_green,
                           blue:  p0_req_ff.write_blue};
      end
   end

   // ------------------------------------------------------------------
   // P2: dividends for the divider; write row and face.
   // ------------------------------------------------------------------
   logic [DIR_W-1:0] p2_a_ff;
   logic [RW-1:0]    p2_du_ff, p2_dv_ff;
   meta_type         p2_meta_ff;

   always_ff @(posedge clock) begin
      if (ld[ST_P2]) begin
         p2_a_ff           <= p1_a_ff;
         p2_du_ff          <= RW'(p1_nu_ff) * RW'(DIV_SCALE);
         p2_dv_ff          <= RW'(p1_nv_ff) * RW'(DIV_SCALE);
         p2_meta_ff.sample <= p1_sample_ff;
         p2_meta_ff.wr_ok  <= p1_wr_ok_ff;
         p2_meta_ff.face   <= p1_sample_ff ? p1_face_ff : p1_q2_ff[2:0];
         p2_meta_ff.row    <= CW'(p1_q1_ff - IDX_W'(p1_q2_ff * IDX_W'(FACE_SIZE)));
         p2_meta_ff.col    <= p1_col_ff;
         p2_meta_ff.tex    <= p1_tex_ff;
      end
   end

   // ------------------------------------------------------------------
   // Divider: restoring long division of both dividends by a, one
   // quotient bit per stage, most significant bit first.
   // ------------------------------------------------------------------
   div_type div_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_div
      div_type       stage_in;
      div_type       stage_out;
      logic [RW-1:0] dsh;

      if (k == 0) begin : g_first
         always_comb begin
            stage_in.a    = p2_a_ff;
            stage_in.ru   = p2_du_ff;
            stage_in.rv   = p2_dv_ff;
            stage_in.qu   = '0;
            stage_in.qv   = '0;
            stage_in.meta = p2_meta_ff;
         end
      end else begin : g_next
         assign stage_in = div_ff[k-1];
      end

      always_comb begin
         dsh       = RW'(stage_in.a) << (QW - 1 - k);
         stage_out = stage_in;
         if (stage_in.ru >= dsh) begin
            stage_out.ru           = stage_in.ru - dsh;
            stage_out.qu[QW-1-k]   = 1'b1;
         end
         if (stage_in.rv >= dsh) begin
            stage_out.rv           = stage_in.rv - dsh;
            stage_out.qv[QW-1-k]   = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (ld[ST_DIV+k]) begin
            div_ff[k] <= stage_out;
         end
      end
   end

   // ------------------------------------------------------------------
   // Texel addressing. The store is split into four banks by row and
   // column parity, so all four taps of the 2x2 footprint are read together;
   // when clamping folds two taps onto one texel they read the same bank entry.
   // All words pass the store in order, so no forwarding is needed.
   // ------------------------------------------------------------------
   div_type          dl;
   logic [PW-1:0]    pu, pv;
   logic [IW-1:0]    iu, iv;
   logic [CW-1:0]    x0, x1, y0, y1;
   logic [CW-1:0]    rsel [4];
   logic [CW-1:0]    csel [4];
   logic [BAW-1:0]   bank_addr [4];
   logic [3:0]       bank_we;

   assign dl = div_ff[QW-1];

   always_comb begin
      pu = PW'(dl.qu) + PW'(128);
      pv = PW'(dl.qv) + PW'(128);
      iu = pu[PW-1:8];
      iv = pv[PW-1:8];
      x0 = (iu == '0) ? '0 : CW'(iu - IW'(1));
      y0 = (iv == '0) ? '0 : CW'(iv - IW'(1));
      x1 = (iu >= IW'(FACE_SIZE)) ? CW'(FACE_SIZE - 1) : CW'(iu);
      y1 = (iv >= IW'(FACE_SIZE)) ? CW'(FACE_SIZE - 1) : CW'(iv);
      for (int b = 0; b < 4; b++) begin
         if (dl.meta.sample) begin
            rsel[b] = (y0[0] == b[1]) ? y0 : y1;
            csel[b] = (x0[0] == b[0]) ? x0 : x1;
         end else begin
            rsel[b] = dl.meta.row;
            csel[b] = dl.meta.col;
         end
         bank_addr[b] = BAW'((BAW'(dl.meta.face) * BAW'(HALF) + BAW'(rsel[b] >> 1))
                             * BAW'(HALF) + BAW'(csel[b] >> 1));
         bank_we[b]   = v_ff[ST_MEM-1] && ld[ST_MEM] && !dl.meta.sample
                        && dl.meta.wr_ok && (dl.meta.row[0] == b[1])
                        && (dl.meta.col[0] == b[0]);
      end
   end

   cmbs_pkg::texel_type rd_ff [4];

   for (genvar b = 0; b < 4; b++) begin : g_bank
      cmbs_pkg::texel_type bank_mem [BANK_DEPTH];

      always_ff @(posedge clock) begin
         if (ld[ST_MEM]) begin
            if (bank_we[b]) begin
               bank_mem[bank_addr[b]] <= dl.meta.tex;
            end
            rd_ff[b] <= bank_mem[bank_addr[b]];
         end
      end
   end

   logic [7:0] m_fx_ff, m_fy_ff;
   logic       m_x0p_ff, m_x1p_ff, m_y0p_ff, m_y1p_ff;

   always_ff @(posedge clock) begin
      if (ld[ST_MEM]) begin
         m_sample_ff <= dl.meta.sample;
         m_fx_ff     <= pu[7:0];
         m_fy_ff     <= pv[7:0];
         m_x0p_ff    <= x0[0];
         m_x1p_ff    <= x1[0];
         m_y0p_ff    <= y0[0];
         m_y1p_ff    <= y1[0];
      end
   end

   // ------------------------------------------------------------------
   // Blend: horizontal pass, then vertical pass with half-up rounding.
   // ------------------------------------------------------------------
   cmbs_pkg::texel_type t00, t01, t10, t11;

   assign t00 = rd_ff[{m_y0p_ff, m_x0p_ff}];
   assign t01 = rd_ff[{m_y0p_ff, m_x1p_ff}];
   assign t10 = rd_ff[{m_y1p_ff, m_x0p_ff}];
   assign t11 = rd_ff[{m_y1p_ff, m_x1p_ff}];

   logic [TW-1:0] b_top_ff [3];
   logic [TW-1:0] b_bot_ff [3];
   logic [7:0]    b_fy_ff;

   always_ff @(posedge clock) begin
      if (ld[ST_BLEND]) begin
         b_top_ff[0] <= lerp_row(t00.red,   t01.red,   m_fx_ff);
         b_top_ff[1] <= lerp_row(t00.green, t01.green, m_fx_ff);
         b_top_ff[2] <= lerp_row(t00.blue,  t01.blue,  m_fx_ff);
         b_bot_ff[0] <= lerp_row(t10.red,   t11.red,   m_fx_ff);
         b_bot_ff[1] <= lerp_row(t10.green, t11.green, m_fx_ff);
         b_bot_ff[2] <= lerp_row(t10.blue,  t11.blue,  m_fx_ff);
         b_fy_ff     <= m_fy_ff;
      end
   end

   cmbs_pkg::rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (ld[ST_OUT]) begin
         rsp_data_ff.red   <= lerp_col(b_top_ff[0], b_bot_ff[0], b_fy_ff);
         rsp_data_ff.green <= lerp_col(b_top_ff[1], b_bot_ff[1], b_fy_ff);
         rsp_data_ff.blue  <= lerp_col(b_top_ff[2], b_bot_ff[2], b_fy_ff);
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

`default_nettype wire

// ----- design/cmbs_checker.sv -----
// Port-level checker for the cube map sampler core, bound into the core module.
// Depends on cmbs_pkg and cube_map_bilinear_sampler_core.
`default_nettype none

module cmbs_checker (
   input wire               clock,
   input wire               reset,
   input wire               req_valid,
   input wire               req_ready,
   input cmbs_pkg::req_type req_data,
   input wire               rsp_valid,
   input wire               rsp_ready,
   input cmbs_pkg::rsp_type rsp_data
);

   // Samples taken whose results have not yet been delivered.
   logic [7:0] pending_ff;
   logic [7:0] pending_in;

   always_comb begin
      pending_in = pending_ff;
      if (req_valid && req_ready && req_data.func == cmbs_pkg::FUNC_SAMPLE) begin
         pending_in = pending_in + 8'd1;
      end
      if (rsp_valid && rsp_ready) begin
         pending_in = pending_in - 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 8'd0)
      else $error("result without a pending sample");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("input stalled while output side is free");

endmodule

bind cube_map_bilinear_sampler_core cmbs_checker u_cmbs_checker (.*);

`default_nettype wire

// ----- tb/cube_map_bilinear_sampler_core_tb.sv -----
// Self-checking testbench for the cube map bilinear sampler core: fills the
// reachable texels, then sends directed and random samples mixed with writes. Depends on
// cmbs_pkg and cube_map_bilinear_sampler_core.
`timescale 1ns / 100ps
`default_nettype none

module cube_map_bilinear_sampler_core_tb;

   localparam int SIZE   = 32;
   localparam int DEPTH  = cmbs_pkg::FACE_COUNT * SIZE * SIZE;
   localparam int IDX_W  = cmbs_pkg::IDX_W;
   localparam int RAD_W  = cmbs_pkg::RAD_W;
   localparam int DIR_W  = cmbs_pkg::DIR_W;
   localparam int LIMIT  = 5000;
   localparam int DRAIN  = 40;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   cmbs_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   cmbs_pkg::rsp_type rsp_data;

   // Shadow copy of the texel store, kept in step with accepted write words.
   cmbs_pkg::texel_type shadow_texels [DEPTH];
   // Filtered colors still owed by the block, oldest first.
   cmbs_pkg::rsp_type   owed_colors [$];
   // Texels that sampling can reach: the central 4x4 block of every face,
   // where near-axis directions land, and the four corners of every face,
   // where exact diagonals land. All of them are written before any sample.
   int unsigned         live_idx [$];

   int errors = 0;
   int samples_sent = 0;
   int writes_sent = 0;
   int colors_seen = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   cube_map_bilinear_sampler_core #(.FACE_SIZE(SIZE)) dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );

   always #4 clock = ~clock;

   // Offset texel position: floor(128*SIZE*(a+sn)/a) + 128, which is the
   // position scaled by 256 plus half a texel so it never goes negative.
   function automatic int unsigned offset_pos(input int a, input int sn);
      longint unsigned p;
      if (a <= 0) return 128 * SIZE + 128;
      p = 128 * SIZE * longint'(a + sn);
      return int'(p / a) + 128;
   endfunction

   function automatic int unsigned clamp_coord(input int i);
      if (i < 0) return 0;
      if (i > SIZE - 1) return SIZE - 1;
      return i;
   endfunction

   function automatic int unsigned texel_at(input int face, input int row, input int col);
      return (face * SIZE + row) * SIZE + col;
   endfunction

   // Bilinear filtered color seen along one direction.
   function automatic cmbs_pkg::rsp_type filtered_color(input cmbs_pkg::req_type w);
      int x, y, z, ax, ay, az, a, su, sv, xf, yf;
      int unsigned face, pu, pv, fx, fy, x0, x1, y0, y1, base;
      cmbs_pkg::texel_type t00, t01, t10, t11;
      longint unsigned top, bot, sum;
      logic [RAD_W-1:0] ch [3];
      cmbs_pkg::rsp_type r;
      x = w.dir_x; y = w.dir_y; z = w.dir_z;
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      az = z < 0 ? -z : z;
      // Ties go to x, then to y; a zero component counts as positive.
      if (ax >= ay && ax >= az) begin
         a = ax;
         if (x >= 0) begin face = cmbs_pkg::FACE_POS_X; su = -z; sv = -y; end
         else begin face = cmbs_pkg::FACE_NEG_X; su = z; sv = -y; end
      end else if (ay >= az) begin
         a = ay;
         if (y >= 0) begin face = cmbs_pkg::FACE_POS_Y; su = x; sv = z; end
         else begin face = cmbs_pkg::FACE_NEG_Y; su = x; sv = -z; end
      end else begin
         a = az;
         if (z >= 0) begin face = cmbs_pkg::FACE_POS_Z; su = x; sv = -y; end
         else begin face = cmbs_pkg::FACE_NEG_Z; su = -x; sv = -y; end
      end
      pu = offset_pos(a, su);
      pv = offset_pos(a, sv);
      xf = int'(pu >> 8) - 1;
      yf = int'(pv >> 8) - 1;
      fx = pu & 255;
      fy = pv & 255;
      x0 = clamp_coord(xf); x1 = clamp_coord(xf + 1);
      y0 = clamp_coord(yf); y1 = clamp_coord(yf + 1);
      base = face * SIZE * SIZE;
      t00 = shadow_texels[base + y0 * SIZE + x0];
      t01 = shadow_texels[base + y0 * SIZE + x1];
      t10 = shadow_texels[base + y1 * SIZE + x0];
      t11 = shadow_texels[base + y1 * SIZE + x1];
      for (int c = 0; c < 3; c++) begin
         longint unsigned v00, v01, v10, v11;
         v00 = t00[RAD_W*(2-c) +: RAD_W];
         v01 = t01[RAD_W*(2-c) +: RAD_W];
         v10 = t10[RAD_W*(2-c) +: RAD_W];
         v11 = t11[RAD_W*(2-c) +: RAD_W];
         top = v00 * (256 - fx) + v01 * fx;
         bot = v10 * (256 - fx) + v11 * fx;
         sum = top * (256 - fy) + bot * fy;
         ch[c] = RAD_W'((sum + 32768) >> 16);
      end
      r.red = ch[0]; r.green = ch[1]; r.blue = ch[2];
      return r;
   endfunction

   // Offers one word and holds it until the block takes it. The predictor is
   // updated at the accepting edge, so a sample sees every earlier write.
   // Valid drops only when the sender decides to idle before this word.
   task automatic send_word(input cmbs_pkg::req_type w);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_data  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      if (w.func == cmbs_pkg::FUNC_WRITE) begin
         if (w.texel_index < DEPTH)
            shadow_texels[w.texel_index] = '{w.write_red, w.write_green, w.write_blue};
         writes_sent++;
      end else begin
         owed_colors.push_back(filtered_color(w));
         samples_sent++;
      end
   endtask

   function automatic cmbs_pkg::req_type write_word(input int idx, input int r,
                                                    input int g, input int b);
      cmbs_pkg::req_type w;
      w = '0;
      w.func = cmbs_pkg::FUNC_WRITE;
      w.texel_index = IDX_W'(idx);
      w.write_red = RAD_W'(r); w.write_green = RAD_W'(g); w.write_blue = RAD_W'(b);
      // Junk in the direction fields must not matter for a write.
      w.dir_x = DIR_W'($urandom); w.dir_y = DIR_W'($urandom); w.dir_z = DIR_W'($urandom);
      return w;
   endfunction

   function automatic cmbs_pkg::req_type sample_word(input int x, input int y, input int z);
      cmbs_pkg::req_type w;
      w = '0;
      w.func = cmbs_pkg::FUNC_SAMPLE;
      w.dir_x = DIR_W'(x); w.dir_y = DIR_W'(y); w.dir_z = DIR_W'(z);
      // Junk in the write fields must not matter for a sample.
      w.texel_index = IDX_W'($urandom); w.write_red = RAD_W'($urandom);
      w.write_green = RAD_W'($urandom); w.write_blue = RAD_W'($urandom);
      return w;
   endfunction

   function automatic int rand_rad();
      case ($urandom_range(3))
         0: return 0;
         1: return 1280000;
         2: return int'($urandom_range(2097151));
         default: return int'($urandom_range(1280000));
      endcase
   endfunction

   // Random sample that only reaches written texels.
   function automatic cmbs_pkg::req_type rand_sample();
      int d [3];
      int a, lim, axis;
      axis = $urandom_range(2);
      case ($urandom_range(5))
         0: begin
            d[0] = 0; d[1] = 0; d[2] = 0;
         end
         1: begin
            // Exact diagonal: all magnitudes tie, so a single corner texel.
            a = $urandom_range(32767, 1);
            for (int i = 0; i < 3; i++)
               d[i] = $urandom_range(1) ? a : -a;
         end
         default: begin
            // Near an axis: the minor components stay within a/16, which
            // keeps the footprint inside the central block of the face.
            a = $urandom_range(3) == 0 ? 32768 : int'($urandom_range(32767, 1));
            lim = a / 16;
            for (int i = 0; i < 3; i++)
               d[i] = int'($urandom_range(2 * lim)) - lim;
            if (a == 32768) d[axis] = -32768;
            else d[axis] = $urandom_range(1) ? a : -a;
         end
      endcase
      return sample_word(d[0], d[1], d[2]);
   endfunction

   // Receiver: random stalls, in-order check against the owed colors.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
         if (rsp_valid && rsp_ready) begin
            colors_seen++;
            if (owed_colors.size() == 0) begin
               $display("%0t: unexpected color word, expected none, actual %h",
                        $time, rsp_data);
               errors++;
            end else begin
               cmbs_pkg::rsp_type e;
               e = owed_colors.pop_front();
               if (rsp_data.red !== e.red) begin
                  $display("%0t: red mismatch, expected %0d, actual %0d",
                           $time, e.red, rsp_data.red);
                  errors++;
               end
               if (rsp_data.green !== e.green) begin
                  $display("%0t: green mismatch, expected %0d, actual %0d",
                           $time, e.green, rsp_data.green);
                  errors++;
               end
               if (rsp_data.blue !== e.blue) begin
                  $display("%0t: blue mismatch, expected %0d, actual %0d",
                           $time, e.blue, rsp_data.blue);
                  errors++;
               end
            end
         end
      end
   end

   // Watchdog: counts cycles in which neither channel moves a word.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= LIMIT) begin
         $display("%0t: watchdog expired, %0d colors still owed", $time,
                  owed_colors.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // One directed row: a word, and where the color can be read off directly,
   // the color it must give (a write row carries no color).
   typedef struct {
      cmbs_pkg::req_type word;
      logic              fixed;
      cmbs_pkg::rsp_type color;
   } row_type;

   initial begin
      row_type rows [$];
      int k;
      for (int f = 0; f < cmbs_pkg::FACE_COUNT; f++) begin
         for (int r = SIZE / 2 - 2; r < SIZE / 2 + 2; r++)
            for (int c = SIZE / 2 - 2; c < SIZE / 2 + 2; c++)
               live_idx.push_back(texel_at(f, r, c));
         live_idx.push_back(texel_at(f, 0, 0));
         live_idx.push_back(texel_at(f, 0, SIZE - 1));
         live_idx.push_back(texel_at(f, SIZE - 1, 0));
         live_idx.push_back(texel_at(f, SIZE - 1, SIZE - 1));
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every reachable texel gets a known value first, so no read ever hits
      // an unwritten entry. Sender runs without gaps here.
      foreach (live_idx[i])
         send_word(write_word(live_idx[i], rand_rad(), rand_rad(), rand_rad()));

      // Directed part. Face 0 is painted flat so the zero direction, the
      // face center and its corner give a color known without the predictor.
      foreach (live_idx[i])
         if (live_idx[i] < SIZE * SIZE)
            rows.push_back('{write_word(live_idx[i], 1280000, 0, 2097151), 1'b0, '0});
      rows.push_back('{sample_word(0, 0, 0), 1'b1, '{1280000, 0, 2097151}});
      rows.push_back('{sample_word(32767, 0, 0), 1'b1, '{1280000, 0, 2097151}});
      rows.push_back('{sample_word(5, 5, 5), 1'b1, '{1280000, 0, 2097151}});
      rows.push_back('{sample_word(-32768, 0, 0), 1'b0, '0});
      rows.push_back('{sample_word(0, 32767, 0), 1'b0, '0});
      rows.push_back('{sample_word(0, -32768, 0), 1'b0, '0});
      rows.push_back('{sample_word(0, 0, 32767), 1'b0, '0});
      rows.push_back('{sample_word(0, 0, -32768), 1'b0, '0});
      rows.push_back('{sample_word(-700, 7, 3), 1'b0, '0});
      rows.push_back('{sample_word(1, -900, 9), 1'b0, '0});
      rows.push_back('{sample_word(32767, -32768, 32767), 1'b0, '0});
      rows.push_back('{sample_word(-32768, -32768, -32768), 1'b0, '0});
      rows.push_back('{sample_word(100, 100, -100), 1'b0, '0});
      // Out-of-range writes must be dropped.
      rows.push_back('{write_word(DEPTH, 0, 0, 0), 1'b0, '0});
      rows.push_back('{write_word(8191, 0, 0, 0), 1'b0, '0});
      rows.push_back('{sample_word(1, 0, 0), 1'b1, '{1280000, 0, 2097151}});
      foreach (rows[i]) begin
         send_word(rows[i].word);
         if (rows[i].fixed && rows[i].word.func == cmbs_pkg::FUNC_SAMPLE
             && owed_colors[$] != rows[i].color) begin
            $display("%0t: row %0d predictor off, expected %h, actual %h", $time,
                     i, rows[i].color, owed_colors[$]);
            errors++;
         end
      end

      // Random part in three idling phases; mostly samples over a live store.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = phase == 0 ? 23 : (phase == 1 ? 59 : 0);
         recv_idle_pct = phase == 0 ? 59 : (phase == 1 ? 23 : 0);
         for (int n = 0; n < 165; n++) begin
            if ($urandom_range(3) == 0) begin
               k = $urandom_range(15) == 0 ? $urandom_range(8191)
                                           : $urandom_range(DEPTH - 1);
               send_word(write_word(k, rand_rad(), rand_rad(), rand_rad()));
            end else begin
               send_word(rand_sample());
            end
         end
      end
      req_valid <= 1'b0;

      while (owed_colors.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      $display("Covered %0d write words and %0d sample words; %0d colors checked.",
               writes_sent, samples_sent, colors_seen);
      $display("Idling phases: sender 23/receiver 59, sender 59/receiver 23, none.");
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

`default_nettype wire
